[design/irb_pkg.sv]
package irb_pkg;

    localparam int STORE_WORDS = 1024;
    localparam int MAX_VALUES  = 16;
    localparam int ACT_W       = 3;
    localparam int IDX_W       = 16;
    localparam int CNT_W       = 5;
    localparam int VAL_W       = 32;

    typedef enum logic [ACT_W-1:0] {
        ACT_CLEAR  = 3'd0,
        ACT_BEGIN  = 3'd1,
        ACT_APPEND = 3'd2,
        ACT_REWIND = 3'd3,
        ACT_READ   = 3'd4
    } t_action;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic rewind;
        logic begin_ok;
        logic begin_drop;
        logic append;
        logic fill;
        logic req;
        logic rd_hdr0;
        logic rd_hdr1;
        logic advance;
        logic hit;
        logic miss;
        logic load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic fits;
        logic pend_nz;
        logic fill_done;
        logic at_end;
        logic idx_gt;
        logic hit_pend;
        logic out_free;
        logic out_last;
    } t_stat;

endpackage

[design/irb_in_if.sv]
interface irb_in_if;
    logic                     valid;
    logic                     ready;
    logic [2:0]               action;
    logic [15:0]              rec_index;
    logic [4:0]               value_count;
    logic signed [31:0]       value;
    logic [4:0]               want_count;

    modport source (
        output valid, action, rec_index, value_count, value, want_count,
        input  ready
    );
    modport sink (
        input  valid, action, rec_index, value_count, value, want_count,
        output ready
    );
endinterface

[design/irb_out_if.sv]
interface irb_out_if;
    logic                     valid;
    logic                     ready;
    logic signed [31:0]       read_value;
    logic                     value_valid;
    logic [4:0]               copied_count;
    logic                     overflow;
    logic                     last;

    modport source (
        output valid, read_value, value_valid, copied_count, overflow, last,
        input  ready
    );
    modport sink (
        input  valid, read_value, value_valid, copied_count, overflow, last,
        output ready
    );
endinterface

[design/irb_ram.sv]
module irb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/irb_ctrl.sv]
module irb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  irb_pkg::t_action i_action,
    output logic            o_in_ready,
    output irb_pkg::t_cmd   o_cmd,
    input  irb_pkg::t_stat  i_stat
);
    import irb_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_SCAN,
        S_HDR0,
        S_HDR1,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_action)
                        ACT_CLEAR:  o_cmd.clear = 1'b1;
                        ACT_BEGIN: begin
                            if (i_stat.fits) begin
                                o_cmd.begin_ok = 1'b1;
                                n_state        = S_FILL;
                            end else begin
                                o_cmd.begin_drop = 1'b1;
                            end
                        end
                        ACT_APPEND: o_cmd.append = i_stat.pend_nz;
                        ACT_REWIND: o_cmd.rewind = 1'b1;
                        ACT_READ: begin
                            o_cmd.req = 1'b1;
                            n_state   = S_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            S_FILL: begin
                o_cmd.fill = 1'b1;
                if (i_stat.fill_done) begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (i_stat.at_end) begin
                    o_cmd.miss = 1'b1;
                    n_state    = S_EMIT;
                end else begin
                    o_cmd.rd_hdr0 = 1'b1;
                    n_state       = S_HDR0;
                end
            end
            S_HDR0: begin
                // larger index ends the scan with the cursor on that record
                if (i_stat.idx_gt) begin
                    o_cmd.miss = 1'b1;
                    n_state    = S_EMIT;
                end else begin
                    o_cmd.rd_hdr1 = 1'b1;
                    n_state       = S_HDR1;
                end
            end
            S_HDR1: begin
                o_cmd.advance = 1'b1;
                if (i_stat.hit_pend) begin
                    o_cmd.hit = 1'b1;
                    n_state   = S_EMIT;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    if (i_stat.out_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[design/irb_dpath.sv]
module irb_dpath #(
    parameter int STORE_WORDS = irb_pkg::STORE_WORDS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  irb_pkg::t_cmd               i_cmd,
    output irb_pkg::t_stat              o_stat,
    input  logic [irb_pkg::IDX_W-1:0]   i_rec_index,
    input  logic [irb_pkg::CNT_W-1:0]   i_value_count,
    input  logic signed [irb_pkg::VAL_W-1:0] i_value,
    input  logic [irb_pkg::CNT_W-1:0]   i_want_count,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [irb_pkg::VAL_W-1:0] o_read_value,
    output logic                        o_value_valid,
    output logic [irb_pkg::CNT_W-1:0]   o_copied_count,
    output logic                        o_overflow,
    output logic                        o_last
);
    import irb_pkg::*;

    localparam int AW = $clog2(STORE_WORDS);
    localparam int PW = AW + 1;
    localparam int SW = AW + 2;
    localparam int FW = $clog2(MAX_VALUES + 2);

    logic [PW-1:0]    r_wend;
    logic [PW-1:0]    r_cur;
    logic [CNT_W-1:0] r_pend;
    logic             r_ovf;
    logic [CNT_W-1:0] r_rcnt;
    logic [AW-1:0]    r_fptr;
    logic [FW-1:0]    r_fleft;
    logic             r_ffirst;
    logic [IDX_W-1:0] r_idx;
    logic [CNT_W-1:0] r_want;
    logic [CNT_W-1:0] r_last_i;
    logic             r_hit;
    logic [CNT_W-1:0] r_copied;
    logic [AW-1:0]    r_src;
    logic [CNT_W-1:0] r_i;
    logic             r_out_valid;
    logic [VAL_W-1:0] r_read_value;
    logic             r_value_valid;
    logic [CNT_W-1:0] r_copied_count;
    logic             r_overflow;
    logic             r_last;

    logic [CNT_W-1:0] vcnt_sat;
    logic [CNT_W-1:0] want_sat;
    logic [SW-1:0]    rec_end;
    logic [CNT_W-1:0] ram_rcnt;
    logic [CNT_W-1:0] hit_copy;
    logic [CNT_W-1:0] next_i;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [VAL_W-1:0] ram_wdata;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    logic [VAL_W-1:0] ram_rdata;

    irb_ram #(
        .WIDTH (VAL_W),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign vcnt_sat = (i_value_count > CNT_W'(MAX_VALUES)) ? CNT_W'(MAX_VALUES)
                                                           : i_value_count;
    assign want_sat = (i_want_count > CNT_W'(MAX_VALUES)) ? CNT_W'(MAX_VALUES)
                                                          : i_want_count;
    assign rec_end  = SW'(r_wend) + SW'(2) + SW'(vcnt_sat);
    assign ram_rcnt = ram_rdata[CNT_W-1:0];
    assign hit_copy = (r_want < ram_rcnt) ? r_want : ram_rcnt;
    assign next_i   = r_i + CNT_W'(1);

    // single write port: header word, value append or fill sweep
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        if (i_cmd.begin_ok) begin
            ram_we    = 1'b1;
            ram_waddr = r_wend[AW-1:0];
            ram_wdata = VAL_W'(i_rec_index);
        end else if (i_cmd.append) begin
            ram_we    = 1'b1;
            ram_waddr = AW'(r_wend - PW'(r_pend));
            ram_wdata = i_value;
        end else if (i_cmd.fill) begin
            ram_we    = 1'b1;
            ram_waddr = r_fptr;
            ram_wdata = r_ffirst ? VAL_W'(r_rcnt) : '0;
        end
    end

    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = '0;
        if (i_cmd.rd_hdr0) begin
            ram_re    = 1'b1;
            ram_raddr = r_cur[AW-1:0];
        end else if (i_cmd.rd_hdr1) begin
            ram_re    = 1'b1;
            ram_raddr = AW'(r_cur + PW'(1));
        end else if (i_cmd.hit) begin
            ram_re    = 1'b1;
            ram_raddr = AW'(r_cur + PW'(2));
        end else if (i_cmd.load) begin
            // prefetch the next value while this one goes out
            ram_re    = (next_i < r_copied);
            ram_raddr = r_src + AW'(next_i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wend      <= '0;
            r_cur       <= '0;
            r_pend      <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_wend <= '0;
                r_cur  <= '0;
                r_pend <= '0;
                r_ovf  <= 1'b0;
            end
            if (i_cmd.rewind) begin
                r_cur <= '0;
            end
            if (i_cmd.begin_drop) begin
                r_ovf  <= 1'b1;
                r_pend <= '0;
            end
            if (i_cmd.begin_ok) begin
                r_wend <= PW'(rec_end);
                r_pend <= vcnt_sat;
            end
            if (i_cmd.append) begin
                r_pend <= r_pend - CNT_W'(1);
            end
            if (i_cmd.advance) begin
                r_cur <= r_cur + PW'(2) + PW'(ram_rcnt);
            end
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.begin_ok) begin
            r_rcnt   <= vcnt_sat;
            r_fptr   <= AW'(r_wend + PW'(1));
            r_fleft  <= FW'(vcnt_sat) + FW'(1);
            r_ffirst <= 1'b1;
        end
        if (i_cmd.fill) begin
            r_fptr   <= r_fptr + AW'(1);
            r_fleft  <= r_fleft - FW'(1);
            r_ffirst <= 1'b0;
        end
        if (i_cmd.req) begin
            r_idx    <= i_rec_index;
            r_want   <= want_sat;
            r_last_i <= (want_sat == '0) ? '0 : want_sat - CNT_W'(1);
        end
        if (i_cmd.rd_hdr1) begin
            r_hit <= (ram_rdata == VAL_W'(r_idx));
        end
        if (i_cmd.hit) begin
            r_copied <= hit_copy;
            r_src    <= AW'(r_cur + PW'(2));
            r_i      <= '0;
        end
        if (i_cmd.miss) begin
            r_copied <= '0;
            r_i      <= '0;
        end
        if (i_cmd.load) begin
            r_read_value   <= (r_i < r_copied) ? ram_rdata : '0;
            r_value_valid  <= (r_want != '0);
            r_copied_count <= r_copied;
            r_overflow     <= r_ovf;
            r_last         <= (r_i == r_last_i);
            r_i            <= next_i;
        end
    end

    assign o_stat.fits      = (rec_end <= SW'(STORE_WORDS));
    assign o_stat.pend_nz   = (r_pend != '0);
    assign o_stat.fill_done = (r_fleft == FW'(1));
    assign o_stat.at_end    = (r_cur >= r_wend);
    assign o_stat.idx_gt    = (ram_rdata > VAL_W'(r_idx));
    assign o_stat.hit_pend  = r_hit;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;
    assign o_stat.out_last  = (r_i == r_last_i);

    assign o_out_valid    = r_out_valid;
    assign o_read_value   = r_read_value;
    assign o_value_valid  = r_value_valid;
    assign o_copied_count = r_copied_count;
    assign o_overflow     = r_overflow;
    assign o_last         = r_last;

endmodule

[design/indexed_record_bank.sv]
// Packed bank of variable-length records (index, value count, then up to 16
// 32-bit values) held in one single-port-write RAM of STORE_WORDS words, with
// records appended at a write end and found by a forward scan from a read
// cursor. One input word is handled at a time. Clear, rewind, append and a
// dropped record complete in the cycle they are accepted; a begun record
// writes its header and zero-filled slots through the one RAM write port. A
// read steps through the SCAN, HDR0 and HDR1 states for each header it
// examines, the found record included (header reads through the registered
// RAM port); a larger index ends the scan in HDR0 and the write end in SCAN.
// Then come the result words, max(want, 1) of them, one per cycle while the
// sink keeps ready high. The RAM content is undefined after reset and needs
// no clearing pass: nothing at or past the write end is ever used. A record
// that does not fit sets a sticky overflow.
module indexed_record_bank #(
    parameter int STORE_WORDS = irb_pkg::STORE_WORDS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    irb_in_if.sink     i_in,
    irb_out_if.source  o_out
);
    import irb_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    irb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_action   (t_action'(i_in.action)),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    irb_dpath #(
        .STORE_WORDS (STORE_WORDS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_rec_index    (i_in.rec_index),
        .i_value_count  (i_in.value_count),
        .i_value        (i_in.value),
        .i_want_count   (i_in.want_count),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_read_value   (o_out.read_value),
        .o_value_valid  (o_out.value_valid),
        .o_copied_count (o_out.copied_count),
        .o_overflow     (o_out.overflow),
        .o_last         (o_out.last)
    );

endmodule

[design/irb_checker.sv]
module irb_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [2:0]  i_in_action,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_read_value,
    input  logic        i_value_valid,
    input  logic [4:0]  i_copied_count,
    input  logic        i_last
);
    import irb_pkg::*;

    // stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_read_value)
            && $stable(i_last) && $stable(i_copied_count))
        else $error("stalled output word changed");

    // read with nothing wanted gives one empty final word
    a_want0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_value_valid |-> i_last && (i_read_value == '0)
            && (i_copied_count == '0))
        else $error("empty read word malformed");

    // a stored value only comes from a hit, and copies stay within one record
    a_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_copied_count <= 5'(MAX_VALUES))
            && ((i_read_value == '0) || (i_copied_count != '0)))
        else $error("value without a copied record");

    // a read occupies the block, so no input is taken right after it
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_action == ACT_READ) |=> !i_in_ready)
        else $error("input taken right after a read");

endmodule

bind indexed_record_bank irb_checker u_irb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_action    (i_in.action),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_read_value   (o_out.read_value),
    .i_value_valid  (o_out.value_valid),
    .i_copied_count (o_out.copied_count),
    .i_last         (o_out.last)
);

[dv/irb_checker.sv]
`timescale 1ns / 100ps

module irb_scoreboard
    import irb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    irb_in_if           i_in,
    irb_out_if          i_out,
    output int unsigned o_fail_count,
    output int unsigned o_expect_level
);

    localparam int unsigned HDR_WORDS = 2;

    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        logic                    value_valid;
        logic [CNT_W-1:0]        copied_count;
        logic                    overflow;
        logic                    last;
    } t_read_word;

    logic [VAL_W-1:0] bank_words [STORE_WORDS];
    int unsigned      write_end;
    int unsigned      read_cursor;
    int unsigned      values_pending;
    logic             overflow_seen;
    t_read_word       read_words_due [$];
    t_read_word       head_word;
    int unsigned      fail_total = 0;

    function automatic int unsigned clamp_count(input logic [CNT_W-1:0] c);
        return (c > MAX_VALUES) ? MAX_VALUES : int'(c);
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
            fail_total++;
        end
    endtask

    // one accepted input word: update the bank image, queue the read results
    task automatic model_word(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] idx,
                              input logic [CNT_W-1:0] vcnt, input logic [VAL_W-1:0] val,
                              input logic [CNT_W-1:0] want_raw);
        int unsigned cnt;
        int unsigned want;
        int unsigned off;
        int unsigned src;
        int unsigned copied;
        int unsigned n;
        int unsigned rec_idx;
        int unsigned rec_cnt;
        bit          done;
        t_read_word  w;
        cnt  = clamp_count(vcnt);
        want = clamp_count(want_raw);
        case (act)
            ACT_CLEAR: begin
                write_end      = 0;
                read_cursor    = 0;
                values_pending = 0;
                overflow_seen  = 1'b0;
            end
            ACT_BEGIN: begin
                if (write_end + HDR_WORDS + cnt > STORE_WORDS) begin
                    overflow_seen  = 1'b1;
                    values_pending = 0;
                end else begin
                    bank_words[write_end]     = VAL_W'(idx);
                    bank_words[write_end + 1] = VAL_W'(cnt);
                    for (int i = 0; i < cnt; i++)
                        bank_words[write_end + HDR_WORDS + i] = '0;
                    write_end      = write_end + HDR_WORDS + cnt;
                    values_pending = cnt;
                end
            end
            ACT_APPEND: begin
                if (values_pending != 0) begin
                    bank_words[write_end - values_pending] = val;
                    values_pending--;
                end
            end
            ACT_REWIND: begin
                read_cursor = 0;
            end
            ACT_READ: begin
                off    = read_cursor;
                src    = 0;
                copied = 0;
                done   = 1'b0;
                // skip smaller indices, stop at a larger one or at the write end
                while (!done && off < write_end) begin
                    rec_idx = bank_words[off];
                    rec_cnt = bank_words[off + 1];
                    if (rec_idx > idx) begin
                        done = 1'b1;
                    end else if (rec_idx < idx) begin
                        off = off + HDR_WORDS + rec_cnt;
                    end else begin
                        copied = (want < rec_cnt) ? want : rec_cnt;
                        src    = off + HDR_WORDS;
                        off    = off + HDR_WORDS + rec_cnt;
                        done   = 1'b1;
                    end
                end
                read_cursor = off;
                n = (want == 0) ? 1 : want;
                for (int i = 0; i < n; i++) begin
                    w.read_value   = (i < copied) ? bank_words[src + i] : '0;
                    w.value_valid  = (want != 0);
                    w.copied_count = CNT_W'(copied);
                    w.overflow     = overflow_seen;
                    w.last         = (i + 1 == n);
                    read_words_due.push_back(w);
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            write_end      = 0;
            read_cursor    = 0;
            values_pending = 0;
            overflow_seen  = 1'b0;
            read_words_due.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (read_words_due.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, actual %h",
                             $time, i_out.read_value);
                    fail_total++;
                end else begin
                    head_word = read_words_due.pop_front();
                    check_field("read_value", head_word.read_value, i_out.read_value);
                    check_field("value_valid", 32'(head_word.value_valid),
                                32'(i_out.value_valid));
                    check_field("copied_count", 32'(head_word.copied_count),
                                32'(i_out.copied_count));
                    check_field("overflow", 32'(head_word.overflow), 32'(i_out.overflow));
                    check_field("last", 32'(head_word.last), 32'(i_out.last));
                end
            end
            if (i_in.valid && i_in.ready)
                model_word(i_in.action, i_in.rec_index, i_in.value_count, i_in.value,
                           i_in.want_count);
        end
        o_fail_count   <= fail_total;
        o_expect_level <= read_words_due.size();
    end

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps

module tb;
    import irb_pkg::*;

    localparam int unsigned ITEM_TARGET   = 220;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned SETTLE_CYCLES = 64;
    localparam int unsigned IDLE_LIMIT    = 4000;
    localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

    logic        i_clk;
    logic        i_rst_n;
    bit          quiet;
    bit          long_hold;
    int unsigned sent_items;
    int unsigned idle_cycles;
    int unsigned fail_count;
    int unsigned expect_level;

    irb_in_if  in_ch ();
    irb_out_if out_ch ();

    indexed_record_bank u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    irb_scoreboard u_chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in           (in_ch),
        .i_out          (out_ch),
        .o_fail_count   (fail_count),
        .o_expect_level (expect_level)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int unsigned draw_gap();
        if (quiet || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    function automatic logic [CNT_W-1:0] pick_count();
        if ($urandom_range(0, 7) == 0)
            return CNT_W'($urandom_range(17, 31));
        return CNT_W'($urandom_range(0, 16));
    endfunction

    function automatic logic [CNT_W-1:0] rnd5();
        return CNT_W'($urandom);
    endfunction

    function automatic logic [IDX_W-1:0] rnd16();
        return IDX_W'($urandom);
    endfunction

    task automatic send_word(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] idx,
                             input logic [CNT_W-1:0] cnt, input logic [VAL_W-1:0] val,
                             input logic [CNT_W-1:0] want);
        int unsigned gap;
        gap = draw_gap();
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.action      <= act;
        in_ch.rec_index   <= idx;
        in_ch.value_count <= cnt;
        in_ch.value       <= val;
        in_ch.want_count  <= want;
        do @(posedge i_clk); while (!in_ch.ready);
        if (act <= ACT_READ)
            sent_items++;
    endtask

    task automatic send_noise();
        send_word(ACT_W'($urandom), rnd16(), rnd5(), $urandom, rnd5());
    endtask

    // stop offering words until every read word has come back, then let the block settle
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expect_level != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_directed();
        send_word(ACT_READ, 16'd0, rnd5(), $urandom, 5'd5);
        send_word(ACT_READ, 16'hFFFF, rnd5(), $urandom, 5'd0);
        send_word(ACT_BEGIN, 16'd0, 5'd0, $urandom, rnd5());
        send_word(ACT_BEGIN, 16'd5, 5'd3, $urandom, rnd5());
        send_word(ACT_APPEND, rnd16(), rnd5(), 32'h8000_0000, rnd5());
        send_word(ACT_APPEND, rnd16(), rnd5(), 32'h7FFF_FFFF, rnd5());
        send_word(ACT_APPEND, rnd16(), rnd5(), 32'hFFFF_FFFF, rnd5());
        // nothing pending any more
        send_word(ACT_APPEND, rnd16(), rnd5(), 32'h1234_5678, rnd5());
        // count above the maximum saturates
        send_word(ACT_BEGIN, 16'hFFFF, 5'd31, $urandom, rnd5());
        send_word(ACT_APPEND, rnd16(), rnd5(), 32'hA5A5_5A5A, rnd5());
        send_word(ACT_APPEND, rnd16(), rnd5(), 32'h0000_0001, rnd5());
        // new record while the previous one is still partly unfilled
        send_word(ACT_BEGIN, 16'd7, 5'd2, $urandom, rnd5());
        send_word(ACT_APPEND, rnd16(), rnd5(), 32'hDEAD_BEEF, rnd5());
        send_word(ACT_SPARE_LO, rnd16(), rnd5(), $urandom, rnd5());
        send_word(ACT_SPARE_HI, rnd16(), rnd5(), $urandom, rnd5());
        send_word(ACT_READ, 16'd0, rnd5(), $urandom, 5'd0);
        send_word(ACT_READ, 16'd5, rnd5(), $urandom, 5'd2);
        send_word(ACT_READ, 16'hFFFF, rnd5(), $urandom, 5'd31);
        send_word(ACT_READ, 16'd7, rnd5(), $urandom, 5'd16);
        send_word(ACT_READ, 16'd7, rnd5(), $urandom, 5'd3);
        // out of order after a rewind: the lower index is passed over
        send_word(ACT_REWIND, rnd16(), rnd5(), $urandom, rnd5());
        send_word(ACT_READ, 16'hFFFF, rnd5(), $urandom, 5'd1);
        send_word(ACT_READ, 16'd5, rnd5(), $urandom, 5'd4);
        send_word(ACT_CLEAR, rnd16(), rnd5(), $urandom, rnd5());
        send_word(ACT_READ, 16'd0, rnd5(), $urandom, 5'd2);
    endtask

    // fill the bank to the last word, then drop records on overflow
    task automatic fill_bank();
        send_word(ACT_CLEAR, rnd16(), rnd5(), $urandom, rnd5());
        for (int i = 0; i < 56; i++) begin
            send_word(ACT_BEGIN, IDX_W'(i * 16), 5'd16, $urandom, rnd5());
            if (i % 20 == 3)
                repeat (2) send_word(ACT_APPEND, rnd16(), rnd5(), $urandom, rnd5());
        end
        send_word(ACT_BEGIN, 16'd1000, 5'd14, $urandom, rnd5());
        send_word(ACT_BEGIN, 16'd1100, 5'd0, $urandom, rnd5());
        send_word(ACT_APPEND, rnd16(), rnd5(), $urandom, rnd5());
        send_word(ACT_REWIND, rnd16(), rnd5(), $urandom, rnd5());
        send_word(ACT_READ, 16'd48, rnd5(), $urandom, 5'd16);
        send_word(ACT_READ, 16'd880, rnd5(), $urandom, 5'd16);
        send_word(ACT_READ, 16'd1000, rnd5(), $urandom, 5'd16);
        send_word(ACT_READ, 16'd1100, rnd5(), $urandom, 5'd3);
        send_word(ACT_CLEAR, rnd16(), rnd5(), $urandom, rnd5());
    endtask

    task automatic run_session(input bit with_hold);
        logic [IDX_W-1:0]   keys [$];
        logic [IDX_W-1:0]   key;
        logic [IDX_W-1:0]   ask;
        logic [CNT_W-1:0]   cnt;
        int unsigned        nrec;
        int unsigned        nfill;
        int unsigned        nreads;
        int unsigned        k;
        int unsigned        key_next;
        if ($urandom_range(0, 3) == 0)
            send_word(ACT_CLEAR, rnd16(), rnd5(), $urandom, rnd5());
        nrec = $urandom_range(1, 6);
        key  = IDX_W'($urandom_range(0, 60000));
        for (int r = 0; r < nrec; r++) begin
            cnt = pick_count();
            send_word(ACT_BEGIN, key, cnt, $urandom, rnd5());
            keys.push_back(key);
            nfill = (cnt > MAX_VALUES) ? MAX_VALUES : cnt;
            case ($urandom_range(0, 5))
                0: nfill = $urandom_range(0, nfill);
                1: nfill = nfill + $urandom_range(1, 2);
                default: ;
            endcase
            repeat (nfill) send_word(ACT_APPEND, rnd16(), rnd5(), $urandom, rnd5());
            if ($urandom_range(0, 7) == 0)
                send_noise();
            // a step of zero repeats the index
            key_next = key + $urandom_range(0, 300);
            key = (key_next > 16'hFFFF) ? 16'hFFFF : IDX_W'(key_next);
        end
        send_word(ACT_REWIND, rnd16(), rnd5(), $urandom, rnd5());
        if (with_hold)
            long_hold = 1'b1;
        nreads = with_hold ? 10 : $urandom_range(2, nrec + 3);
        k = 0;
        for (int r = 0; r < nreads; r++) begin
            ask = (k < keys.size()) ? keys[k] : rnd16();
            case ($urandom_range(0, 9))
                7: ask = ask + 16'd1;
                8: ask = rnd16();
                9: send_word(ACT_REWIND, rnd16(), rnd5(), $urandom, rnd5());
                default: ;
            endcase
            send_word(ACT_READ, ask, rnd5(), $urandom, with_hold ? 5'd16 : pick_count());
            k = k + $urandom_range(0, 2);
        end
    endtask

    // stall watchdog
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side
    initial begin
        int unsigned stall;
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (long_hold) begin
                long_hold = 1'b0;
                stall = HOLD_CYCLES;
            end else begin
                stall = draw_gap();
            end
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    // word side
    initial begin
        int unsigned session;
        quiet       = 1'b0;
        long_hold   = 1'b0;
        sent_items  = 0;
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.action      <= ACT_CLEAR;
        in_ch.rec_index   <= '0;
        in_ch.value_count <= '0;
        in_ch.value       <= '0;
        in_ch.want_count  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        session = 0;
        while (sent_items < ITEM_TARGET) begin
            quiet = (session % 4 == 2);
            if (session == 3)
                fill_bank();
            else
                run_session(session == 1);
            if (session == 2 || $urandom_range(0, 4) == 0)
                wait_drained();
            session++;
        end
        quiet = 1'b0;
        wait_drained();

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
